// ===== rtl/bnps_pkg.sv =====
// Package for the bounding-box point set normalizer.
// Holds widths, the point record type and the sequencer state type.
// No dependencies.
package bnps_pkg;

  // Field widths.
  localparam int COORD_W = 32;
  localparam int SPAN_W  = 24;

  // Quotient width: the scaled offset never exceeds the target span.
  localparam int QUO_W   = SPAN_W;
  localparam int PROD_W  = SPAN_W + COORD_W;
  localparam int SUM_W   = COORD_W + 2;
  localparam int STEP_W  = $clog2(QUO_W);

  // One stored point.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      pe;
  } pt_t;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_PREP = 6'b000010,
    ST_RD   = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

endpackage

// ===== rtl/bbox_normalize_point_set.sv =====
// Top level of the bounding-box point set normalizer.
// Depends on bnps_pkg for widths, the point record and the state type.
//
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_ready  in_pos_x, in_pos_y, in_path_end, in_set_end
// out_      output     out_valid/out_ready out_new_x, out_new_y, out_path_end_out,
//                                          out_last_out, out_zero_extent, out_overflowed
// cfg_      input      cfg_wr_en          cfg_wr_data (target span)
//
// Points load into the store at one transaction per cycle while in_ready is high.
// After the transaction with in_set_end the block computes the extents, then works
// through each stored point in turn: memory read, multiply, 24 radix-2 divider steps
// and the final add and saturate. The divider sets the emit rate while out_ready stays high.
// in_ready stays low from the set_end transaction until the last result is loaded.
// A result waits in the output register; the next point is computed meanwhile.
// Reset is synchronous; the point store is not cleared and needs no pass.
module bbox_normalize_point_set
  import bnps_pkg::*;
#(
  parameter int POINT_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input channel.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic                      in_path_end,
  input  logic                      in_set_end,
  // Result channel.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_new_x,
  output logic signed [COORD_W-1:0] out_new_y,
  output logic                      out_path_end_out,
  output logic                      out_last_out,
  output logic                      out_zero_extent,
  output logic                      out_overflowed,
  // Configuration port.
  input  logic                      cfg_wr_en,
  input  logic [SPAN_W-1:0]         cfg_wr_data
);

  localparam int AW = $clog2(POINT_DEPTH);
  localparam int CW = $clog2(POINT_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(POINT_DEPTH);

  // Control state.
  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic                      drop_r, drop_nxt;
  logic signed [COORD_W-1:0] min_r [2];
  logic signed [COORD_W-1:0] max_r [2];
  logic signed [COORD_W-1:0] min_nxt [2];
  logic signed [COORD_W-1:0] max_nxt [2];
  logic [SPAN_W-1:0]         target_r;
  logic                      out_valid_r;

  // Point store and its registered read port.
  pt_t                       mem [POINT_DEPTH];
  pt_t                       rd_data_r;

  // Datapath registers.
  logic [COORD_W-1:0]        ext_r [2];
  logic                      scale_r [2];
  logic                      zero_ext_r;
  logic signed [COORD_W-1:0] pos_r [2];
  logic                      pe_r;
  logic [COORD_W-1:0]        rem_r [2];
  logic [COORD_W-1:0]        rem_nxt [2];
  logic [QUO_W-1:0]          nq_r [2];
  logic [QUO_W-1:0]          nq_nxt [2];
  logic signed [COORD_W-1:0] out_x_r, out_y_r;
  logic                      out_pe_r, out_last_r, out_zero_r, out_ovf_r;

  // Combinational helpers.
  logic signed [COORD_W-1:0] pos_in [2];
  logic signed [COORD_W-1:0] pos_rd [2];
  logic [COORD_W-1:0]        diff [2];
  logic [PROD_W-1:0]         prod [2];
  logic [COORD_W:0]          trial [2];
  logic                      ge [2];
  logic signed [SUM_W-1:0]   sum [2];
  logic signed [COORD_W-1:0] res [2];
  logic                      accept, full, store_en, is_last, out_load;

  assign pos_in[0] = in_pos_x;
  assign pos_in[1] = in_pos_y;
  assign pos_rd[0] = rd_data_r.x;
  assign pos_rd[1] = rd_data_r.y;

  assign in_ready = (state_r == ST_LOAD);
  assign accept   = in_valid & in_ready;
  assign full     = (count_r == DEPTH_C);
  assign store_en = accept & ~full;
  assign is_last  = ((CW'(idx_r) + CW'(1)) == count_r);
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // Sequencer and set bookkeeping.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    drop_nxt  = drop_r;
    for (int a = 0; a < 2; a++) begin
      min_nxt[a] = min_r[a];
      max_nxt[a] = max_r[a];
    end
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (!full) begin
            count_nxt = count_r + CW'(1);
            for (int a = 0; a < 2; a++) begin
              if (pos_in[a] < min_r[a]) min_nxt[a] = pos_in[a];
              if (pos_in[a] > max_r[a]) max_nxt[a] = pos_in[a];
            end
          end else begin
            drop_nxt = 1'b1;
          end
          // An accepted point always leaves the store non-empty, so a set end
          // always leads to an emit.
          if (in_set_end) begin
            state_nxt = ST_PREP;
            idx_nxt   = '0;
          end
        end
      end
      ST_PREP: state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_MUL;
      ST_MUL: begin
        state_nxt = ST_DIV;
        step_nxt  = STEP_W'(QUO_W - 1);
      end
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_FIN: begin
        if (out_load) begin
          if (is_last) begin
            state_nxt = ST_LOAD;
            count_nxt = '0;
            drop_nxt  = 1'b0;
            for (int a = 0; a < 2; a++) begin
              min_nxt[a] = {1'b0, {(COORD_W-1){1'b1}}};
              max_nxt[a] = {1'b1, {(COORD_W-1){1'b0}}};
            end
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      idx_r       <= '0;
      step_r      <= '0;
      drop_r      <= 1'b0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        min_r[a] <= {1'b0, {(COORD_W-1){1'b1}}};
        max_r[a] <= {1'b1, {(COORD_W-1){1'b0}}};
      end
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
      drop_r  <= drop_nxt;
      for (int a = 0; a < 2; a++) begin
        min_r[a] <= min_nxt[a];
        max_r[a] <= max_nxt[a];
      end
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Point store: one write port while loading, one registered read port.
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[count_r[AW-1:0]] <= '{x: in_pos_x, y: in_pos_y, pe: in_path_end};
    end
    rd_data_r <= mem[idx_r];
  end

  // Offset from the minimum, product with the target, and one divider step per axis.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      diff[a]    = pos_rd[a] - min_r[a];
      prod[a]    = PROD_W'(target_r) * PROD_W'(diff[a]);
      trial[a]   = {rem_r[a], nq_r[a][QUO_W-1]};
      ge[a]      = (trial[a] >= {1'b0, ext_r[a]});
      rem_nxt[a] = ge[a] ? COORD_W'(trial[a] - {1'b0, ext_r[a]}) : trial[a][COORD_W-1:0];
      nq_nxt[a]  = {nq_r[a][QUO_W-2:0], ge[a]};
    end
  end

  // Minimum plus quotient, rounded toward zero, saturated high; else pass-through.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sum[a] = SUM_W'(min_r[a]) + SUM_W'(signed'({1'b0, nq_r[a]}));
      if ((rem_r[a] != '0) && sum[a][SUM_W-1]) begin
        sum[a] = sum[a] + SUM_W'(1);
      end
      if (!sum[a][SUM_W-1] && (sum[a][SUM_W-2:COORD_W-1] != '0)) begin
        res[a] = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        res[a] = sum[a][COORD_W-1:0];
      end
      if (!scale_r[a]) begin
        res[a] = pos_r[a];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_PREP: begin
        for (int a = 0; a < 2; a++) begin
          ext_r[a]   <= max_r[a] - min_r[a];
          scale_r[a] <= (target_r != '0) && (max_r[a] != min_r[a]);
        end
        zero_ext_r <= (target_r != '0) && ((max_r[0] == min_r[0]) || (max_r[1] == min_r[1]));
      end
      ST_MUL: begin
        pe_r <= rd_data_r.pe;
        for (int a = 0; a < 2; a++) begin
          pos_r[a] <= pos_rd[a];
          rem_r[a] <= prod[a][PROD_W-1:QUO_W];
          nq_r[a]  <= prod[a][QUO_W-1:0];
        end
      end
      ST_DIV: begin
        for (int a = 0; a < 2; a++) begin
          rem_r[a] <= rem_nxt[a];
          nq_r[a]  <= nq_nxt[a];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_x_r    <= res[0];
      out_y_r    <= res[1];
      out_pe_r   <= pe_r;
      out_last_r <= is_last;
      out_zero_r <= zero_ext_r;
      out_ovf_r  <= drop_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_x        = out_x_r;
  assign out_new_y        = out_y_r;
  assign out_path_end_out = out_pe_r;
  assign out_last_out     = out_last_r;
  assign out_zero_extent  = out_zero_r;
  assign out_overflowed   = out_ovf_r;

endmodule

// ===== rtl/bnps_checker.sv =====
// Port-level checker for the bounding-box point set normalizer, with its bind.
// Depends on bnps_pkg for widths and on the top level's port names.
module bnps_port_assert
  import bnps_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic signed [COORD_W-1:0] in_pos_x,
  input logic signed [COORD_W-1:0] in_pos_y,
  input logic                      in_path_end,
  input logic                      in_set_end,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [COORD_W-1:0] out_new_x,
  input logic signed [COORD_W-1:0] out_new_y,
  input logic                      out_path_end_out,
  input logic                      out_last_out,
  input logic                      out_zero_extent,
  input logic                      out_overflowed,
  input logic                      cfg_wr_en,
  input logic [SPAN_W-1:0]         cfg_wr_data
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_x) && $stable(out_new_y)
      && $stable(out_last_out))
    else $error("result changed while stalled");

  // A set-end transaction, which starts an emit, closes the input.
  a_set_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_set_end |=> !in_ready)
    else $error("input still open after set end");

  // Reset leaves the block ready for input with no pending result.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("bad state after reset");

  // The overflow flag does not change between consecutive results of one set.
  a_flags_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_out ##1 out_valid
      |-> $stable(out_overflowed) || !$past(out_valid))
    else $error("set flag changed within a set");

endmodule

bind bbox_normalize_point_set bnps_port_assert u_bnps_port_assert (.*);

// ===== tb/sv/bnps_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the bounding-box point set normalizer. It predicts every rescaled point
// from the observed point and span transactions and checks it against the results. Depends on bnps_pkg for widths.
module bnps_checker
  import bnps_pkg::*;
#(
  parameter int POINT_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic                      in_path_end,
  input  logic                      in_set_end,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [COORD_W-1:0] out_new_x,
  input  logic signed [COORD_W-1:0] out_new_y,
  input  logic                      out_path_end_out,
  input  logic                      out_last_out,
  input  logic                      out_zero_extent,
  input  logic                      out_overflowed,
  input  logic                      cfg_wr_en,
  input  logic [SPAN_W-1:0]         cfg_wr_data,
  output int                        fail_count,
  output int                        pending,
  output int                        checked
);

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  // One predicted output point.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      path_end;
    logic                      last;
    logic                      zero_ext;
    logic                      dropped;
  } scaled_point_t;

  scaled_point_t due_points[$];

  // Shadow of the point store, the running bounds and the span register.
  longint            keep_x[POINT_DEPTH];
  longint            keep_y[POINT_DEPTH];
  logic              keep_pe[POINT_DEPTH];
  longint            lo_x, hi_x, lo_y, hi_y;
  int                n_kept;
  logic              lost_points;
  logic [SPAN_W-1:0] span;

  int n_fail    = 0;
  int n_due     = 0;
  int n_checked = 0;

  assign fail_count = n_fail;
  assign pending    = n_due;
  assign checked    = n_checked;

  // Start a new point set with empty bounds.
  task automatic clear_bounds();
    lo_x        = COORD_MAX;
    lo_y        = COORD_MAX;
    hi_x        = COORD_MIN;
    hi_y        = COORD_MIN;
    n_kept      = 0;
    lost_points = 1'b0;
  endtask

  // Exact lo + tgt*(p-lo)/extent, truncated toward zero, then saturated to 32 bits.
  function automatic logic signed [COORD_W-1:0] rescale_axis(longint p, longint lo,
                                                             longint unsigned extent,
                                                             longint unsigned tgt);
    longint unsigned prod, quo, rem;
    longint          sum;
    prod = tgt * (p - lo);
    quo  = prod / extent;
    rem  = prod % extent;
    sum  = lo + $signed(quo);
    if (rem != 0 && sum < 0) sum = sum + 1;
    if (sum > COORD_MAX) sum = COORD_MAX;
    if (sum < COORD_MIN) sum = COORD_MIN;
    return sum[COORD_W-1:0];
  endfunction

  // Store one point; on the set end, queue every stored point rescaled.
  task automatic take_point(input logic signed [COORD_W-1:0] px, py, input logic pe, se);
    longint        vx, vy, ext_x, ext_y;
    logic          flat;
    scaled_point_t pt;
    vx = px;
    vy = py;
    if (n_kept < POINT_DEPTH) begin
      keep_x[n_kept]  = vx;
      keep_y[n_kept]  = vy;
      keep_pe[n_kept] = pe;
      n_kept++;
      if (vx < lo_x) lo_x = vx;
      if (vx > hi_x) hi_x = vx;
      if (vy < lo_y) lo_y = vy;
      if (vy > hi_y) hi_y = vy;
    end else begin
      lost_points = 1'b1;
    end
    if (se) begin
      ext_x = hi_x - lo_x;
      ext_y = hi_y - lo_y;
      flat  = (span != 0) && (ext_x == 0 || ext_y == 0);
      for (int i = 0; i < n_kept; i++) begin
        pt.x = keep_x[i][COORD_W-1:0];
        pt.y = keep_y[i][COORD_W-1:0];
        if (span != 0 && ext_x != 0) pt.x = rescale_axis(keep_x[i], lo_x, ext_x, span);
        if (span != 0 && ext_y != 0) pt.y = rescale_axis(keep_y[i], lo_y, ext_y, span);
        pt.path_end = keep_pe[i];
        pt.last     = (i == n_kept - 1);
        pt.zero_ext = flat;
        pt.dropped  = lost_points;
        due_points.insert(due_points.size(), pt);
      end
      clear_bounds();
    end
  endtask

  // Watch all three ports at each rising edge; results are compared before new points
  // are absorbed, which keeps the queue in emission order.
  always @(posedge clk) begin : watch
    scaled_point_t want;
    logic          bad;
    if (!rst_n) begin
      span = '0;
      clear_bounds();
      due_points.delete();
    end else begin
      if (cfg_wr_en) span = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (due_points.size() == 0) begin
          if (n_fail < 10)
            $display("%0t: unexpected result x=%0d y=%0d last=%b", $realtime,
                     out_new_x, out_new_y, out_last_out);
          n_fail++;
        end else begin
          want = due_points[0];
          due_points.delete(0);
          bad  = (out_new_x !== want.x) || (out_new_y !== want.y) ||
                 (out_path_end_out !== want.path_end) || (out_last_out !== want.last) ||
                 (out_zero_extent !== want.zero_ext) || (out_overflowed !== want.dropped);
          if (bad) begin
            if (n_fail < 10) begin
              $display("%0t: mismatch on result %0d", $realtime, n_checked);
              $display("  expected x=%0d y=%0d pe=%b last=%b zext=%b ovf=%b",
                       want.x, want.y, want.path_end, want.last, want.zero_ext,
                       want.dropped);
              $display("  actual   x=%0d y=%0d pe=%b last=%b zext=%b ovf=%b",
                       out_new_x, out_new_y, out_path_end_out, out_last_out,
                       out_zero_extent, out_overflowed);
            end
            n_fail++;
          end
          n_checked++;
        end
      end
      if (in_valid && in_ready) take_point(in_pos_x, in_pos_y, in_path_end, in_set_end);
    end
    n_due = due_points.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the testbench for bbox_normalize_point_set: drives point sets and span writes
// and gives the verdict. Depends on bnps_pkg, the block and bnps_checker.
module tb_top
  import bnps_pkg::*;
;

  localparam int                        DEPTH         = 64;
  localparam int                        CYCLE_LIMIT   = 500000;
  localparam int                        SETTLE_CYCLES = 40;
  localparam int                        TAIL_CYCLES   = 64;
  localparam int                        HOLD_CYCLES   = 500;
  localparam int                        TARGET_POINTS = 400;
  localparam logic [SPAN_W-1:0]         SPAN_MAX      = 24'hFFFFFF;
  localparam logic signed [COORD_W-1:0] COORD_TOP     = 32'h7FFFFFFF;
  localparam logic signed [COORD_W-1:0] COORD_BOTTOM  = 32'h80000000;

  // How the coordinates of one axis are spread over a random set.
  typedef enum {
    SPREAD_FULL,
    SPREAD_CLUSTER,
    SPREAD_TOP,
    SPREAD_BOTTOM,
    SPREAD_FLAT
  } spread_t;

  // Output back-pressure patterns.
  typedef enum {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE
  } ready_mode_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_pos_x;
  logic signed [COORD_W-1:0] in_pos_y;
  logic                      in_path_end;
  logic                      in_set_end;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [COORD_W-1:0] out_new_x;
  logic signed [COORD_W-1:0] out_new_y;
  logic                      out_path_end_out;
  logic                      out_last_out;
  logic                      out_zero_extent;
  logic                      out_overflowed;
  logic                      cfg_wr_en;
  logic [SPAN_W-1:0]         cfg_wr_data;

  int fail_count;
  int pending;
  int checked;

  int burst_left  = 0;
  int n_points    = 0;
  int n_sets      = 0;
  int n_spans     = 0;
  int cycle_count = 0;
  bit hold_req    = 1'b0;

  bbox_normalize_point_set #(
    .POINT_DEPTH(DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_path_end      (in_path_end),
    .in_set_end       (in_set_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_x        (out_new_x),
    .out_new_y        (out_new_y),
    .out_path_end_out (out_path_end_out),
    .out_last_out     (out_last_out),
    .out_zero_extent  (out_zero_extent),
    .out_overflowed   (out_overflowed),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  bnps_checker #(
    .POINT_DEPTH(DEPTH)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_path_end      (in_path_end),
    .in_set_end       (in_set_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_x        (out_new_x),
    .out_new_y        (out_new_y),
    .out_path_end_out (out_path_end_out),
    .out_last_out     (out_last_out),
    .out_zero_extent  (out_zero_extent),
    .out_overflowed   (out_overflowed),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // Result receiver: changing stall patterns, plus one long hold-off on request.
  initial begin
    ready_mode_t mode;
    int          mode_left;
    int          hold_left;
    out_ready = 1'b0;
    mode      = READY_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = ready_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (mode)
          READY_ALWAYS: out_ready = 1'b1;
          READY_HALF:   out_ready = 1'($urandom_range(0, 1));
          default:      out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one point and hold it until the transaction completes. Entered and left at a
  // falling edge; a new burst may start with an idle gap.
  task automatic send_point(input logic signed [COORD_W-1:0] x, y, input logic pe, se);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
    end
    in_valid    = 1'b1;
    in_pos_x    = x;
    in_pos_y    = y;
    in_path_end = pe;
    in_set_end  = se;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    n_points++;
    if (se) n_sets++;
  endtask

  // Pause the sender until every result is out, let the block settle, then write the span.
  task automatic change_span(input logic [SPAN_W-1:0] value);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_data = value;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    n_spans++;
  endtask

  function automatic spread_t pick_spread();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 3) return SPREAD_FULL;
    if (r <= 6) return SPREAD_CLUSTER;
    if (r == 7) return SPREAD_TOP;
    if (r == 8) return SPREAD_BOTTOM;
    return SPREAD_FLAT;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(spread_t s,
                                                           logic signed [COORD_W-1:0] base);
    case (s)
      SPREAD_FULL:    return $urandom;
      SPREAD_CLUSTER: return base + $urandom_range(0, 2000) - 1000;
      SPREAD_TOP:     return COORD_TOP - $urandom_range(0, 500);
      SPREAD_BOTTOM:  return COORD_BOTTOM + $urandom_range(0, 500);
      default:        return base;
    endcase
  endfunction

  function automatic logic [SPAN_W-1:0] pick_span();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return SPAN_MAX;
      2:       return SPAN_W'(1);
      3:       return SPAN_W'($urandom_range(1, 1000));
      default: return SPAN_W'($urandom);
    endcase
  endfunction

  // Mostly short sets, some medium, a few that fill or overrun the store.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(DEPTH + 1, DEPTH + 6);
    if (r == 1) return DEPTH;
    if (r <= 4) return $urandom_range(11, 30);
    return $urandom_range(1, 10);
  endfunction

  task automatic send_random_set(input int len);
    spread_t                   sx, sy;
    logic signed [COORD_W-1:0] bx, by;
    sx = pick_spread();
    sy = pick_spread();
    bx = $urandom;
    by = $urandom;
    for (int i = 0; i < len; i++)
      send_point(pick_coord(sx, bx), pick_coord(sy, by), $urandom_range(0, 3) == 0,
                 i == len - 1);
  endtask

  // Main stimulus sequence and verdict.
  initial begin
    int  sets_in_phase;
    bit  first_set;
    in_valid    = 1'b0;
    in_pos_x    = '0;
    in_pos_y    = '0;
    in_path_end = 1'b0;
    in_set_end  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    rst_n       = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Scaling off: points pass through even with nonzero extents.
    change_span('0);
    send_point(COORD_BOTTOM, COORD_TOP, 1'b1, 1'b1);
    send_point(5, -9, 1'b0, 1'b0);
    send_point(100, 3, 1'b1, 1'b1);

    // Largest span over the full coordinate range, then a set that saturates high.
    change_span(SPAN_MAX);
    send_point(COORD_BOTTOM, COORD_TOP, 1'b0, 1'b0);
    send_point(COORD_TOP, COORD_BOTTOM, 1'b1, 1'b0);
    send_point(0, -1, 1'b0, 1'b0);
    send_point(-1, 0, 1'b1, 1'b1);
    send_point(2147483600, COORD_BOTTOM, 1'b0, 1'b0);
    send_point(COORD_TOP, -2147483600, 1'b1, 1'b1);

    // Small span: negative results truncate toward zero; flat X, then flat Y.
    change_span(10);
    send_point(-100, -7, 1'b0, 1'b0);
    send_point(-97, 20, 1'b0, 1'b0);
    send_point(-99, 3, 1'b1, 1'b1);
    send_point(42, -5, 1'b0, 1'b0);
    send_point(42, 9, 1'b0, 1'b0);
    send_point(42, 1, 1'b1, 1'b1);
    send_point(-3, 77, 1'b1, 1'b0);
    send_point(8, 77, 1'b1, 1'b1);

    // Random phases. The first set overruns the store; while it drains, the receiver
    // holds off for a long stretch and the sender keeps offering the next set.
    first_set = 1'b1;
    while (n_points < TARGET_POINTS) begin
      change_span(pick_span());
      sets_in_phase = $urandom_range(2, 5);
      for (int k = 0; k < sets_in_phase; k++) begin
        if (first_set) begin
          send_random_set(DEPTH + 2);
          hold_req  = 1'b1;
          first_set = 1'b0;
        end else begin
          send_random_set(pick_len());
        end
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d points in %0d sets under %0d span settings; %0d results checked.",
             n_points, n_sets, n_spans, checked);
    $display("Sets included store overruns, saturation, flat axes and a long output stall.");
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bnps_pkg.sv
rtl/bbox_normalize_point_set.sv
rtl/bnps_checker.sv
tb/sv/bnps_checker.sv
tb/sv/tb_top.sv
